// ----- sv/ucsdec_pkg.sv -----
package ucsdec_pkg;

  typedef enum logic [1:0] {
    JOB_CHAR,
    JOB_ERR,
    JOB_TERM
  } job_kind_e;

  // one queued piece of work for the output side
  typedef struct packed {
    job_kind_e   kind;
    logic        four;
    logic [20:0] code;
  } job_t;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VAL   = 8'h80;
  localparam logic [7:0] TERM_HI    = 8'hFF;
  localparam logic [7:0] TERM_LO    = 8'hFE;

endpackage

// ----- sv/ucsdec_front.sv -----
module ucsdec_front
  import ucsdec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [1:0]  owed_q, owed_d;
  logic [20:0] acc_q, acc_d;
  logic        four_q, four_d;
  logic        hold_q, hold_d;
  logic [20:0] acc_cont;

  assign acc_cont = {acc_q[14:0], in_byte_i[5:0]};

  always_comb begin
    owed_d      = owed_q;
    acc_d       = acc_q;
    four_d      = four_q;
    hold_d      = hold_q;
    push_o      = 1'b0;
    job_o.kind  = JOB_ERR;
    job_o.four  = 1'b0;
    job_o.code  = '0;
    if (accept_i) begin
      priority if (end_of_text_i) begin
        owed_d = '0;
        acc_d  = '0;
        four_d = 1'b0;
        hold_d = 1'b0;
        if (!hold_q) begin
          push_o     = 1'b1;
          job_o.kind = (owed_q != 2'd0) ? JOB_ERR : JOB_TERM;
        end
      end else if (hold_q) begin
        // dropping bytes until the end marker
      end else if (owed_q != 2'd0) begin
        if ((in_byte_i & CONT_MASK) != CONT_VAL) begin
          push_o = 1'b1;
          owed_d = '0;
          acc_d  = '0;
          four_d = 1'b0;
          hold_d = 1'b1;
        end else begin
          owed_d = owed_q - 2'd1;
          acc_d  = acc_cont;
          if (owed_q == 2'd1) begin
            push_o     = 1'b1;
            job_o.kind = JOB_CHAR;
            job_o.four = four_q;
            job_o.code = acc_cont;
            acc_d      = '0;
            four_d     = 1'b0;
          end
        end
      end else if (!in_byte_i[7]) begin
        push_o     = 1'b1;
        job_o.kind = JOB_CHAR;
        job_o.code = {13'd0, in_byte_i};
        acc_d      = '0;
        four_d     = 1'b0;
      end else if ((in_byte_i & LEAD2_MASK) == LEAD2_VAL) begin
        acc_d  = {16'd0, in_byte_i[4:0]};
        four_d = 1'b0;
        owed_d = 2'd1;
      end else if ((in_byte_i & LEAD3_MASK) == LEAD3_VAL) begin
        acc_d  = {17'd0, in_byte_i[3:0]};
        four_d = 1'b0;
        owed_d = 2'd2;
      end else if ((in_byte_i & LEAD4_MASK) == LEAD4_VAL) begin
        acc_d  = {18'd0, in_byte_i[2:0]};
        four_d = 1'b1;
        owed_d = 2'd3;
      end else begin
        push_o = 1'b1;
        owed_d = '0;
        acc_d  = '0;
        four_d = 1'b0;
        hold_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
      acc_q  <= '0;
      four_q <= 1'b0;
      hold_q <= 1'b0;
    end else begin
      owed_q <= owed_d;
      acc_q  <= acc_d;
      four_q <= four_d;
      hold_q <= hold_d;
    end
  end

endmodule

// ----- sv/ucsdec_fifo.sv -----
module ucsdec_fifo
  import ucsdec_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- sv/ucsdec_back.sv -----
module ucsdec_back
  import ucsdec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       q_job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       bad_input_o,
  output logic       terminator_o
);

  localparam logic [1:0] STEP_HI  = 2'd0;
  localparam logic [1:0] STEP_MID = 2'd1;
  localparam logic [1:0] STEP_LO  = 2'd2;

  job_t       job_q;
  logic       job_valid_q;
  logic [1:0] step_q;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       last_q, bad_q, term_q;

  logic [7:0] byte_c;
  logic       last_c, bad_c, term_c;
  logic       emit, finish;

  always_comb begin
    byte_c = '0;
    last_c = 1'b1;
    bad_c  = 1'b0;
    term_c = 1'b0;
    unique case (job_q.kind)
      JOB_CHAR: begin
        unique case (step_q)
          STEP_HI:  byte_c = {3'd0, job_q.code[20:16]};
          STEP_MID: byte_c = job_q.code[15:8];
          default:  byte_c = job_q.code[7:0];
        endcase
        last_c = (step_q == STEP_LO);
      end
      JOB_ERR: begin
        bad_c = 1'b1;
      end
      JOB_TERM: begin
        byte_c = (step_q == STEP_HI) ? TERM_HI : TERM_LO;
        last_c = (step_q != STEP_HI);
        term_c = 1'b1;
      end
      default: begin
        bad_c = 1'b1;
      end
    endcase
  end

  // the output register frees up when its transaction completes
  assign emit   = job_valid_q && (!out_valid_q || out_ready_i);
  assign finish = emit && last_c;
  assign pop_o  = q_valid_i && (!job_valid_q || finish);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      step_q      <= STEP_HI;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        job_valid_q <= 1'b1;
        step_q      <= (q_job_i.kind == JOB_CHAR && !q_job_i.four) ? STEP_MID : STEP_HI;
      end else if (finish) begin
        job_valid_q <= 1'b0;
      end else if (emit) begin
        step_q <= step_q + 2'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_job_i;
    end
    if (emit) begin
      byte_q <= byte_c;
      last_q <= last_c;
      bad_q  <= bad_c;
      term_q <= term_c;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign run_last_o   = last_q;
  assign bad_input_o  = bad_q;
  assign terminator_o = term_q;

endmodule

// ----- sv/utf8_to_ucs_bytes_decoder_core.sv -----
// UTF-8 to big-endian code point bytes. One input byte is taken per cycle while
// the job queue (QueueDepth entries) has room; the output side sends one byte
// per cycle while it holds a job and the output is not stalled. A one-, two-
// or three-byte character gives two output bytes, a four-byte character three,
// the end marker two (FF, FE), and an error one. Sustained rate is set by the
// single output byte lane. The first result byte of an input transaction passes
// through the job queue, the job register and the output register.
module utf8_to_ucs_bytes_decoder_core
  import ucsdec_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       bad_input_o,
  output logic       terminator_o
);

  logic accept;
  logic push, full, pop, q_valid;
  job_t push_job, q_job;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  ucsdec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .job_o         (push_job)
  );

  ucsdec_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  ucsdec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_job_i      (q_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .bad_input_o  (bad_input_o),
    .terminator_o (terminator_o)
  );

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("job popped from an empty queue");

  a_error_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_input_o) |-> (out_byte_o == 8'd0 && run_last_o && !terminator_o))
    else $error("malformed error transaction");

  a_push_needs_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> accept)
    else $error("job pushed without an input transaction");

endmodule

// ----- tb/sv/utf8_to_ucs_bytes_decoder_core_test.sv -----
module utf8_to_ucs_bytes_decoder_core_test
  import ucsdec_pkg::*;
();

  localparam int StallLimit = 2000;
  localparam int ReportCap  = 60;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
    logic       term;
  } ucs_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       bad_input_o;
  logic       terminator_o;

  // decoder state as predicted
  logic [1:0]  owed_q;
  logic [20:0] code_q;
  logic        four_q;
  logic        held_q;

  ucs_byte_t pending_ucs_bytes[$];
  int        mismatches = 0;
  int        sent_items = 0;
  int        quiet_cycles = 0;
  bit        idle_on = 1'b1;

  utf8_to_ucs_bytes_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .bad_input_o   (bad_input_o),
    .terminator_o  (terminator_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (mismatches < ReportCap) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void push_ucs(input logic [7:0] data, input logic last,
                                   input logic bad, input logic term);
    ucs_byte_t e;
    e.data = data;
    e.last = last;
    e.bad  = bad;
    e.term = term;
    pending_ucs_bytes.push_back(e);
  endfunction

  function automatic void raise_decode_error();
    owed_q = 2'd0;
    code_q = '0;
    four_q = 1'b0;
    held_q = 1'b1;
    push_ucs(8'h00, 1'b1, 1'b1, 1'b0);
  endfunction

  function automatic void emit_code_point();
    if (four_q) push_ucs({3'b000, code_q[20:16]}, 1'b0, 1'b0, 1'b0);
    push_ucs(code_q[15:8], 1'b0, 1'b0, 1'b0);
    push_ucs(code_q[7:0], 1'b1, 1'b0, 1'b0);
    code_q = '0;
    four_q = 1'b0;
  endfunction

  function automatic void decode_utf8_byte(input logic [7:0] b, input logic eot);
    if (eot) begin
      if (!held_q) begin
        if (owed_q != 2'd0) begin
          push_ucs(8'h00, 1'b1, 1'b1, 1'b0);
        end else begin
          push_ucs(TERM_HI, 1'b0, 1'b0, 1'b1);
          push_ucs(TERM_LO, 1'b1, 1'b0, 1'b1);
        end
      end
      owed_q = 2'd0;
      code_q = '0;
      four_q = 1'b0;
      held_q = 1'b0;
    end else if (!held_q) begin
      if (owed_q != 2'd0) begin
        if ((b & CONT_MASK) != CONT_VAL) begin
          raise_decode_error();
        end else begin
          code_q = {code_q[14:0], b[5:0]};
          owed_q = owed_q - 2'd1;
          if (owed_q == 2'd0) emit_code_point();
        end
      end else if (!b[7]) begin
        code_q = {13'd0, b};
        four_q = 1'b0;
        emit_code_point();
      end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
        code_q = {16'd0, b[4:0]};
        four_q = 1'b0;
        owed_q = 2'd1;
      end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
        code_q = {17'd0, b[3:0]};
        four_q = 1'b0;
        owed_q = 2'd2;
      end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
        code_q = {18'd0, b[2:0]};
        four_q = 1'b1;
        owed_q = 2'd3;
      end else begin
        raise_decode_error();
      end
    end
  endfunction

  // one input transaction, with random idle cycles ahead of it while idle_on is set
  task automatic send_item(input logic [7:0] b, input logic eot);
    while (idle_on && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    decode_utf8_byte(b, eot);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_ucs_bytes.size() != 0);
  endtask

  // result side: random stalls while idle_on is set, and the check of every transaction
  always @(posedge clk_i) begin
    ucs_byte_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ucs_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %h", out_byte_o));
      end else begin
        e = pending_ucs_bytes.pop_front();
        if (out_byte_o !== e.data)
          report_mismatch($sformatf("out_byte %h, want %h", out_byte_o, e.data));
        if (run_last_o !== e.last)
          report_mismatch($sformatf("run_last %b, want %b", run_last_o, e.last));
        if (bad_input_o !== e.bad)
          report_mismatch($sformatf("bad_input %b, want %b", bad_input_o, e.bad));
        if (terminator_o !== e.term)
          report_mismatch($sformatf("terminator %b, want %b", terminator_o, e.term));
      end
    end
    out_ready_i <= idle_on ? ($urandom_range(99) >= 18) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_single_byte_range();
    send_item(8'h00, 1'b0);
    send_item(8'h7F, 1'b0);
  endtask

  task automatic test_multibyte_chars();
    send_item(8'hC2, 1'b0);
    send_item(8'hA9, 1'b0);
    send_item(8'hE2, 1'b0);
    send_item(8'h82, 1'b0);
    send_item(8'hAC, 1'b0);
    // widest code point the four-byte form can carry
    send_item(8'hF7, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_bad_leads();
    send_item(8'h80, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_bad_continuation();
    send_item(8'hC3, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_end_inside_sequence();
    send_item(8'hF0, 1'b0);
    send_item(8'h9F, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_drain_pause();
    send_item(8'h41, 1'b0);
    wait_drained();
    send_item(8'h00, 1'b1);
    wait_drained();
  endtask

  // mostly well formed texts with random content, some noise and broken runs
  task automatic test_random_text(input int n_items, input bit idle);
    int         start;
    int         n_chars;
    int         kind;
    int         len;
    int         n_cont;
    logic [7:0] b;
    idle_on <= idle;
    start = sent_items;
    while (sent_items - start < n_items) begin
      n_chars = $urandom_range(1, 10);
      for (int c = 0; c < n_chars; c++) begin
        kind = $urandom_range(99);
        if (kind < 6) begin
          send_item(8'($urandom_range(255)), 1'b0);
        end else begin
          len = $urandom_range(1, 4);
          b = 8'($urandom_range(255));
          case (len)
            1:       b[7]   = 1'b0;
            2:       b[7:5] = 3'b110;
            3:       b[7:4] = 4'b1110;
            default: b[7:3] = 5'b11110;
          endcase
          send_item(b, 1'b0);
          n_cont = (kind < 12 && len > 1) ? len - 2 : len - 1;
          for (int k = 1; k <= n_cont; k++) begin
            b = 8'($urandom_range(255));
            if (kind >= 12 && kind < 17 && k == n_cont) begin
              if (b[7:6] == 2'b10) b[6] = 1'b1;
            end else begin
              b[7:6] = 2'b10;
            end
            send_item(b, 1'b0);
          end
        end
      end
      send_item(8'($urandom_range(255)), 1'b1);
      if ($urandom_range(24) == 0) wait_drained();
    end
  endtask

  initial begin
    owed_q = 2'd0;
    code_q = '0;
    four_q = 1'b0;
    held_q = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_byte_range();
    test_multibyte_chars();
    test_bad_leads();
    test_bad_continuation();
    test_end_inside_sequence();
    test_drain_pause();
    test_random_text(190, 1'b1);
    test_random_text(95, 1'b0);
    test_random_text(120, 1'b1);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pending_ucs_bytes.size() != 0)
      report_mismatch($sformatf("%0d result bytes never came", pending_ucs_bytes.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ucsdec_pkg.sv
sv/ucsdec_front.sv
sv/ucsdec_fifo.sv
sv/ucsdec_back.sv
sv/utf8_to_ucs_bytes_decoder_core.sv
tb/sv/utf8_to_ucs_bytes_decoder_core_test.sv
